/* hw/rtl/tmtw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_pkg: shared types and constants of the text-mode terminal writer
// Field widths, command codes and character codes used by all modules.
// ----------------------------------------------------------------------------
package tmtw_pkg;

   localparam int KIND_W = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [ATTR_W-1:0] attr_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;

   // command codes
   localparam kind_type KIND_PUT   = 2'd0;
   localparam kind_type KIND_ERASE = 2'd1;
   localparam kind_type KIND_CLEAR = 2'd2;
   localparam kind_type KIND_READ  = 2'd3;

   // character and attribute codes
   localparam char_type NEWLINE_CODE = 8'd10;
   localparam char_type BLANK_CODE   = 8'd32;
   localparam attr_type RESET_COLOR  = 8'd10;

endpackage : tmtw_pkg
`default_nettype wire

/* hw/rtl/tmtw_cell_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_cell_store: screen cell memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tmtw_cell_store #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire tmtw_pkg::cell_type   wr_data,
   input  wire logic [AW-1:0]        rd_addr,
   output tmtw_pkg::cell_type        rd_data
);
   import tmtw_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : tmtw_cell_store
`default_nettype wire

/* hw/rtl/tmtw_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_sequencer: command sequencer of the terminal writer
// Keeps the cursor, drives the cell store ports and walks the store for
// clear, scroll and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tmtw_sequencer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int AW      = 11,
   parameter int RW      = 5,
   parameter int CW      = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request beat
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tmtw_pkg::kind_type   req_kind,
   input  wire tmtw_pkg::char_type   req_character,
   input  wire tmtw_pkg::row_type    req_read_row,
   input  wire tmtw_pkg::col_type    req_read_column,
   input  wire tmtw_pkg::attr_type   text_color,
   // result hand-off to the output register
   input  wire logic                 slot_free,
   output logic                      load,
   output tmtw_pkg::cell_type        load_value,
   output tmtw_pkg::row_type         load_row,
   output tmtw_pkg::col_type         load_column,
   // cell store ports
   output logic                      wr_en,
   output logic [AW-1:0]             wr_addr,
   output tmtw_pkg::cell_type        wr_data,
   output logic [AW-1:0]             rd_addr,
   input  wire tmtw_pkg::cell_type   rd_data
);
   import tmtw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FILL   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_ERASE  = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_END    = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);
   localparam logic [CW-1:0] LAST_COLUMN = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);

   logic [2:0]    state_ff,     state_in;
   logic [RW-1:0] row_ff,       row_in;
   logic [CW-1:0] col_ff,       col_in;
   logic [AW-1:0] cnt_ff,       cnt_in;
   attr_type      fill_attr_ff, fill_attr_in;
   logic          fill_init_ff, fill_init_in;
   cell_type      value_ff,     value_in;

   logic          accept;
   logic          col_last;
   logic          row_last;
   logic          read_in_range;
   logic [AW-1:0] cursor_addr;
   logic [AW-1:0] read_addr;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign col_last      = (col_ff == LAST_COLUMN);
   assign row_last      = (row_ff == LAST_ROW);
   assign read_in_range = (32'(req_read_row) < ROWS) && (32'(req_read_column) < COLUMNS);
   assign cursor_addr   = AW'(row_ff) * ROW_STRIDE + AW'(col_ff);
   assign read_addr     = AW'(req_read_row) * ROW_STRIDE + AW'(req_read_column);

   // read port: copy source during scroll, else the requested cell
   assign rd_addr = (state_ff == ST_SCROLL) ? (cnt_ff + ROW_STRIDE) : read_addr;

   // next state, cursor and store writes
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      fill_attr_in = fill_attr_ff;
      fill_init_in = fill_init_ff;
      value_in     = value_ff;
      wr_en        = 1'b0;
      wr_addr      = cursor_addr;
      wr_data      = {text_color, BLANK_CODE};
      load         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = '0;
               state_in = ST_RESP;
               case (req_kind)
                  KIND_PUT: begin
                     if (req_character != NEWLINE_CODE) begin
                        wr_en   = 1'b1;
                        wr_data = {text_color, req_character};
                     end
                     if (req_character == NEWLINE_CODE || col_last) begin
                        col_in = '0;
                        if (row_last) begin
                           cnt_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  KIND_ERASE: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end else if (row_ff != '0) begin
                        row_in = row_ff - 1'b1;
                        col_in = LAST_COLUMN;
                     end
                     state_in = ST_ERASE;
                  end
                  KIND_CLEAR: begin
                     row_in       = '0;
                     col_in       = '0;
                     cnt_in       = '0;
                     fill_attr_in = text_color;
                     fill_init_in = 1'b0;
                     state_in     = ST_FILL;
                  end
                  default: begin
                     if (read_in_range) begin
                        state_in = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_FILL: begin
            // blank one cell per cycle up to the last cell
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = {fill_attr_ff, BLANK_CODE};
            if (cnt_ff == LAST_CELL) begin
               state_in = fill_init_ff ? ST_IDLE : ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCROLL: begin
            // copy the cell read last cycle one row up
            wr_en   = (cnt_ff != '0);
            wr_addr = cnt_ff - 1'b1;
            wr_data = rd_data;
            if (cnt_ff == COPY_END) begin
               fill_attr_in = text_color;
               fill_init_in = 1'b0;
               state_in     = ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ERASE: begin
            wr_en    = 1'b1;
            state_in = ST_RESP;
         end
         ST_READ: begin
            value_in = rd_data;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers; reset starts the clearing pass in the reset colour
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         fill_attr_ff <= RESET_COLOR;
         fill_init_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         fill_attr_ff <= fill_attr_in;
         fill_init_ff <= fill_init_in;
      end
   end

   // result value
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign load_value  = value_ff;
   assign load_row    = ROW_W'(row_ff);
   assign load_column = COL_W'(col_ff);

endmodule : tmtw_sequencer
`default_nettype wire

/* hw/rtl/text_mode_terminal_writer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_terminal_writer: text console engine over a ROWS x COLUMNS store
//
// Request channel (req_*): one beat per command (put character, erase,
// clear, read cell). Result channel (rsp_*): exactly one beat per request,
// carrying the cell read (zero for other commands) and the cursor after it.
// csr_write_enable/csr_write_data load the text colour; write only while
// the block is idle.
// Path of each command, from acceptance to result ready:
//   put, out-of-range read: straight to the result; erase, read: through
//   ST_ERASE or ST_READ; clear: blanks every cell (one store write per cycle);
//   put or newline that scrolls: the single store write port copies one cell
//   per cycle one row up and then blanks the bottom row.
// Reset runs a clearing pass over all ROWS*COLUMNS cells (2000 by default)
// that blanks the store; requests stall until it ends.
// The result sits in an output register; a new request is taken while it
// waits, and the next result holds inside the block until rsp_stall drops.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tmtw_pkg::kind_type   req_kind,
   input  wire tmtw_pkg::char_type   req_character,
   input  wire tmtw_pkg::row_type    req_read_row,
   input  wire tmtw_pkg::col_type    req_read_column,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output tmtw_pkg::cell_type        rsp_cell_value,
   output tmtw_pkg::row_type         rsp_cursor_row,
   output tmtw_pkg::col_type         rsp_cursor_column,
   // configuration
   input  wire logic                 csr_write_enable,
   input  wire tmtw_pkg::attr_type   csr_write_data
);
   import tmtw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   attr_type      text_color_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   cell_type      rsp_value_ff;
   row_type       rsp_row_ff;
   col_type       rsp_col_ff;

   logic          slot_free;
   logic          load;
   cell_type      load_value;
   row_type       load_row;
   col_type       load_column;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   cell_type      wr_data;
   logic [AW-1:0] rd_addr;
   cell_type      rd_data;

   // text colour register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else if (csr_write_enable) begin
         text_color_ff <= csr_write_data;
      end
   end

   tmtw_sequencer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW),
      .RW      (RW),
      .CW      (CW)
   ) u_sequencer (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_character   (req_character),
      .req_read_row    (req_read_row),
      .req_read_column (req_read_column),
      .text_color      (text_color_ff),
      .slot_free       (slot_free),
      .load            (load),
      .load_value      (load_value),
      .load_row        (load_row),
      .load_column     (load_column),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   tmtw_cell_store #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_cell_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register: free when empty or its beat leaves this cycle
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload until a new beat loads
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff <= load_value;
         rsp_row_ff   <= load_row;
         rsp_col_ff   <= load_column;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;

endmodule : text_mode_terminal_writer
`default_nettype wire
